/* hw/rtl/bounded_price_level_book_assert.svh */
// Assertion macros shared by the price level book RTL.
// All of them sample on clk_i and are off while rst_ni is low.
`ifndef BOUNDED_PRICE_LEVEL_BOOK_ASSERT_SVH
`define BOUNDED_PRICE_LEVEL_BOOK_ASSERT_SVH

// expr holds at every edge
`define BPL_CHK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// cond implies expr in the same cycle
`define BPL_IMPLY(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error(msg);

// cond implies expr in the next cycle
`define BPL_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* hw/rtl/bpl_pkg.sv */
package bpl_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FN_UPD = 2'd0,
    FN_ADD = 2'd1,
    FN_CLR = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    RS_SET      = 3'd0,
    RS_INSERTED = 3'd1,
    RS_EVICTED  = 3'd2,
    RS_REMOVED  = 3'd3,
    RS_IGNORED  = 3'd4,
    RS_DROPPED  = 3'd5,
    RS_CLEARED  = 3'd6
  } status_e;

  // what the level cells do at the apply edge
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_SET,
    CMD_INS,
    CMD_DEL
  } cmd_e;

  // compare phase, broadcast to every cell
  typedef struct packed {
    logic               en;
    logic               is_ask;
    logic [PRICE_W-1:0] price;
  } cell_eval_t;

  // update phase, broadcast to every cell
  typedef struct packed {
    logic               en;
    cmd_e               kind;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cell_cmd_t;

  // one transaction as seen by a side
  typedef struct packed {
    logic [1:0]         func;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } side_req_t;

  typedef struct packed {
    status_e            status;
    logic [PRICE_W-1:0] evicted_price;
    logic               best_valid;
    logic [PRICE_W-1:0] best_price;
    logic [QTY_W-1:0]   best_qty;
    logic [CNT_W-1:0]   count;
  } side_res_t;

endpackage

/* hw/rtl/bpl_cell.sv */
module bpl_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  bpl_pkg::cell_eval_t         eval_i,
  input  bpl_pkg::cell_cmd_t          cmd_i,
  input  logic                        left_ahead_i,
  input  logic [bpl_pkg::PRICE_W-1:0] left_price_i,
  input  logic [bpl_pkg::QTY_W-1:0]   left_qty_i,
  input  logic [bpl_pkg::PRICE_W-1:0] right_price_i,
  input  logic [bpl_pkg::QTY_W-1:0]   right_qty_i,
  output logic                        match_o,
  output logic                        ahead_o,
  output logic [bpl_pkg::PRICE_W-1:0] price_o,
  output logic [bpl_pkg::QTY_W-1:0]   qty_o,
  output logic [bpl_pkg::PRICE_W-1:0] price_next_o,
  output logic [bpl_pkg::QTY_W-1:0]   qty_next_o
);
  import bpl_pkg::*;

  logic               match_q, ahead_q;
  logic [PRICE_W-1:0] price_q, price_d;
  logic [QTY_W-1:0]   qty_q, qty_d;

  // compare phase: flags are taken from the stored level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      ahead_q <= 1'b0;
    end else if (eval_i.en) begin
      match_q <= valid_i && (price_q == eval_i.price);
      ahead_q <= valid_i && (eval_i.is_ask ? (price_q < eval_i.price)
                                           : (price_q > eval_i.price));
    end
  end

  // cells behind the target position shift; sorted order makes !ahead_q
  // mean "at or past the hit / insert point"
  always_comb begin
    price_d = price_q;
    qty_d   = qty_q;
    case (cmd_i.kind)
      CMD_SET: begin
        if (match_q) qty_d = cmd_i.qty;
      end
      CMD_INS: begin
        if (!ahead_q) begin
          if (left_ahead_i) begin
            price_d = cmd_i.price;
            qty_d   = cmd_i.qty;
          end else begin
            price_d = left_price_i;
            qty_d   = left_qty_i;
          end
        end
      end
      CMD_DEL: begin
        if (!ahead_q) begin
          price_d = right_price_i;
          qty_d   = right_qty_i;
        end
      end
      default: begin
        price_d = price_q;
        qty_d   = qty_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      price_q <= price_d;
      qty_q   <= qty_d;
    end
  end

  assign match_o      = match_q;
  assign ahead_o      = ahead_q;
  assign price_o      = price_q;
  assign qty_o        = qty_q;
  assign price_next_o = price_d;
  assign qty_next_o   = qty_d;

endmodule

/* hw/rtl/bpl_side.sv */
`include "bounded_price_level_book_assert.svh"

module bpl_side (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                is_ask_i,
  input  logic                eval_en_i,
  input  logic                apply_en_i,
  input  bpl_pkg::side_req_t  req_i,
  output bpl_pkg::side_res_t  res_o
);
  import bpl_pkg::*;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [DEPTH-1:0]   valid_v, match_v, ahead_v;
  logic [PRICE_W-1:0] price_v [DEPTH];
  logic [QTY_W-1:0]   qty_v [DEPTH];
  logic [PRICE_W-1:0] price_nx_v [DEPTH];
  logic [QTY_W-1:0]   qty_nx_v [DEPTH];
  cell_eval_t         eval;
  cell_cmd_t          cmd;
  cmd_e               kind;
  status_e            status;
  logic [PRICE_W-1:0] evicted;
  logic               hit, full, del;

  assign eval.en     = eval_en_i;
  assign eval.is_ask = is_ask_i;
  assign eval.price  = req_i.price;

  assign cmd.en    = apply_en_i;
  assign cmd.kind  = kind;
  assign cmd.price = req_i.price;
  assign cmd.qty   = req_i.qty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               l_ahead;
    logic [PRICE_W-1:0] l_price, r_price;
    logic [QTY_W-1:0]   l_qty, r_qty;

    assign valid_v[i] = count_q > CNT_W'(i);

    if (i == 0) begin : g_head
      assign l_ahead = 1'b1;
      assign l_price = '0;
      assign l_qty   = '0;
    end else begin : g_mid
      assign l_ahead = ahead_v[i-1];
      assign l_price = price_v[i-1];
      assign l_qty   = qty_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_price = '0;
      assign r_qty   = '0;
    end else begin : g_body
      assign r_price = price_v[i+1];
      assign r_qty   = qty_v[i+1];
    end

    bpl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .valid_i      (valid_v[i]),
      .eval_i       (eval),
      .cmd_i        (cmd),
      .left_ahead_i (l_ahead),
      .left_price_i (l_price),
      .left_qty_i   (l_qty),
      .right_price_i(r_price),
      .right_qty_i  (r_qty),
      .match_o      (match_v[i]),
      .ahead_o      (ahead_v[i]),
      .price_o      (price_v[i]),
      .qty_o        (qty_v[i]),
      .price_next_o (price_nx_v[i]),
      .qty_next_o   (qty_nx_v[i])
    );
  end

  assign hit  = |match_v;
  assign full = count_q == CNT_W'(DEPTH);
  assign del  = (req_i.func == FN_UPD) && (req_i.qty == '0);

  always_comb begin
    kind    = CMD_NONE;
    status  = RS_IGNORED;
    evicted = '0;
    count_d = count_q;
    case (req_i.func)
      FN_CLR: begin
        status  = RS_CLEARED;
        count_d = '0;
      end
      FN_UPD, FN_ADD: begin
        if (hit) begin
          if (del) begin
            kind    = CMD_DEL;
            status  = RS_REMOVED;
            count_d = count_q - CNT_W'(1);
          end else begin
            kind   = CMD_SET;
            status = RS_SET;
          end
        end else if (del) begin
          status = RS_IGNORED;
        end else if (full) begin
          // tail ranks ahead of the new price: nothing to gain
          if (ahead_v[DEPTH-1]) begin
            status = RS_DROPPED;
          end else begin
            kind    = CMD_INS;
            status  = RS_EVICTED;
            evicted = price_v[DEPTH-1];
          end
        end else begin
          kind    = CMD_INS;
          status  = RS_INSERTED;
          count_d = count_q + CNT_W'(1);
        end
      end
      default: begin
        status = RS_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (apply_en_i) begin
      count_q <= count_d;
    end
  end

  assign res_o.status        = status;
  assign res_o.evicted_price = evicted;
  assign res_o.best_valid    = count_d != '0;
  assign res_o.best_price    = (count_d != '0) ? price_nx_v[0] : '0;
  assign res_o.best_qty      = (count_d != '0) ? qty_nx_v[0] : '0;
  assign res_o.count         = count_d;

  `BPL_CHK(a_count_bound, count_q <= CNT_W'(DEPTH), "level count above depth")
  `BPL_CHK(a_unique_price, $onehot0(match_v), "price held by more than one level")
  `BPL_IMPLY(a_del_nonempty, apply_en_i && (kind == CMD_DEL), count_q != '0,
    "removal from an empty side")
  `BPL_NEXT(a_ins_grow, apply_en_i && (status == RS_INSERTED),
    count_q == $past(count_q) + CNT_W'(1), "insert did not grow the side")

endmodule

/* hw/rtl/bounded_price_level_book.sv */
// Bounded two-sided price level book.
// Slave stream: one transaction per book update. tuser carries the opcode
// (update / add-or-set / clear) and the side (bid / ask); tdata carries price
// and quantity. Master stream: one transaction per update with the outcome,
// the evicted tail price, and the best level and level count of that side.
// Each side is a chain of 64 level cells kept sorted best-first. An update
// passes through the chain as a compare cycle in which every cell checks
// its price against the new one, then an apply cycle in which each cell keeps
// its level, takes the new one, or takes a neighbor's to open or close a gap.
// The result enters the output register at the end of the apply cycle.
// The compare/apply pair of the cell chain paces the input; the next input is
// taken in the apply cycle of the update before it.
// A finished result sits in the output register; while it is not taken the
// following update waits in its apply cycle and s_axis_tready stays low.
// Reset empties both sides (level counts go to zero); no clearing pass runs,
// the block takes input in the first cycle after reset.
`include "bounded_price_level_book_assert.svh"

module bounded_price_level_book (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // [31:0] price, [63:32] quantity
  input  logic [2:0]   s_axis_tuser,   // [1:0] func, [2] side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [31:0] evicted_price, [63:32] best_price,
                                       // [95:64] best_quantity,
                                       // [102:96] side_level_count, [103] zero
  output logic [3:0]   m_axis_tuser    // [2:0] status, [3] best_valid
);
  import bpl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_e;

  state_e             state_q;
  logic               m_valid_q;
  side_res_t          res_q;

  // captured transaction
  logic [1:0]         func_q;
  logic               side_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;

  logic               accept, apply_go, eval_en;
  side_req_t          req;
  side_res_t          bid_res, ask_res, sel_res;

  // apply only when the output register is free or being drained
  assign apply_go      = (state_q == ST_APPLY) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || apply_go;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign eval_en       = state_q == ST_EVAL;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= s_axis_tuser[1:0];
      side_q  <= s_axis_tuser[2];
      price_q <= s_axis_tdata[PRICE_W-1:0];
      qty_q   <= s_axis_tdata[63:32];
    end
  end

  assign req.func  = func_q;
  assign req.price = price_q;
  assign req.qty   = qty_q;

  bpl_side u_bid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .is_ask_i  (1'b0),
    .eval_en_i (eval_en),
    .apply_en_i(apply_go && !side_q),
    .req_i     (req),
    .res_o     (bid_res)
  );

  bpl_side u_ask (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .is_ask_i  (1'b1),
    .eval_en_i (eval_en),
    .apply_en_i(apply_go && side_q),
    .req_i     (req),
    .res_o     (ask_res)
  );

  assign sel_res = side_q ? ask_res : bid_res;

  // sequencer plus output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      res_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (apply_go) state_q <= accept ? ST_EVAL : ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (apply_go) begin
        m_valid_q <= 1'b1;
        res_q     <= sel_res;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.count, res_q.best_qty, res_q.best_price,
                          res_q.evicted_price};
  assign m_axis_tuser  = {res_q.best_valid, res_q.status};

  `BPL_IMPLY(a_accept_state, accept, state_q != ST_EVAL, "input taken during compare cycle")
  `BPL_NEXT(a_eval_then_apply, state_q == ST_EVAL, state_q == ST_APPLY,
    "compare cycle not followed by apply")
  `BPL_NEXT(a_apply_result, apply_go, m_valid_q, "applied update left no result")

endmodule

/* tb/sv/tb_bounded_price_level_book.sv */
`timescale 1ns / 100ps

typedef struct {
  logic [1:0]                 func;
  logic                       side;
  logic [bpl_pkg::PRICE_W-1:0] price;
  logic [bpl_pkg::QTY_W-1:0]   qty;
} book_update_t;

typedef struct {
  bpl_pkg::status_e            status;
  logic [bpl_pkg::PRICE_W-1:0] evicted;
  logic                        best_valid;
  logic [bpl_pkg::PRICE_W-1:0] best_price;
  logic [bpl_pkg::QTY_W-1:0]   best_qty;
  logic [bpl_pkg::CNT_W-1:0]   count;
  logic                        pad;
} book_result_t;

// Mirror of both sides of the book plus the queue of outcomes still owed by the block.
class book_mirror;
  logic [bpl_pkg::PRICE_W-1:0] lvl_px  [2*bpl_pkg::DEPTH];
  logic [bpl_pkg::QTY_W-1:0]   lvl_qty [2*bpl_pkg::DEPTH];
  int unsigned                 held [2];
  book_result_t                owed_results [$];
  int unsigned                 error_count;

  function new();
    held[0] = 0;
    held[1] = 0;
    error_count = 0;
  endfunction

  function bit outranks(logic ask, logic [bpl_pkg::PRICE_W-1:0] a,
                        logic [bpl_pkg::PRICE_W-1:0] b);
    return ask ? (a < b) : (a > b);
  endfunction

  function int unsigned levels_held(logic sd);
    return held[sd];
  endfunction

  function logic [bpl_pkg::PRICE_W-1:0] level_price(logic sd, int unsigned idx);
    return lvl_px[(sd ? bpl_pkg::DEPTH : 0) + idx];
  endfunction

  // Apply one accepted update to the mirror and queue its outcome.
  function bpl_pkg::status_e take_update(book_update_t u);
    book_result_t r;
    int unsigned  base, n, hit, pos, i;
    bit           go;
    base = u.side ? bpl_pkg::DEPTH : 0;
    n    = held[u.side];
    hit  = n;
    for (i = 0; i < n; i++)
      if (hit == n && lvl_px[base+i] == u.price) hit = i;
    r.status  = bpl_pkg::RS_IGNORED;
    r.evicted = '0;
    if (u.func == bpl_pkg::FN_CLR) begin
      n = 0;
      r.status = bpl_pkg::RS_CLEARED;
    end else if (u.func == bpl_pkg::FN_UPD || u.func == bpl_pkg::FN_ADD) begin
      if (hit < n) begin
        if (u.func == bpl_pkg::FN_UPD && u.qty == 0) begin
          for (i = hit; i + 1 < n; i++) begin
            lvl_px[base+i]  = lvl_px[base+i+1];
            lvl_qty[base+i] = lvl_qty[base+i+1];
          end
          n--;
          r.status = bpl_pkg::RS_REMOVED;
        end else begin
          lvl_qty[base+hit] = u.qty;
          r.status = bpl_pkg::RS_SET;
        end
      end else if (!(u.func == bpl_pkg::FN_UPD && u.qty == 0)) begin
        go = 1'b1;
        r.status = bpl_pkg::RS_INSERTED;
        if (n >= bpl_pkg::DEPTH) begin
          if (!outranks(u.side, u.price, lvl_px[base+n-1])) begin
            r.status = bpl_pkg::RS_DROPPED;
            go = 1'b0;
          end else begin
            r.evicted = lvl_px[base+n-1];
            n--;
            r.status = bpl_pkg::RS_EVICTED;
          end
        end
        if (go) begin
          pos = 0;
          while (pos < n && outranks(u.side, lvl_px[base+pos], u.price)) pos++;
          for (i = n; i > pos; i--) begin
            lvl_px[base+i]  = lvl_px[base+i-1];
            lvl_qty[base+i] = lvl_qty[base+i-1];
          end
          lvl_px[base+pos]  = u.price;
          lvl_qty[base+pos] = u.qty;
          n++;
        end
      end
    end
    held[u.side]  = n;
    r.best_valid  = (n > 0);
    r.best_price  = (n > 0) ? lvl_px[base] : '0;
    r.best_qty    = (n > 0) ? lvl_qty[base] : '0;
    r.count       = bpl_pkg::CNT_W'(n);
    r.pad         = 1'b0;
    owed_results.push_back(r);
    return r.status;
  endfunction

  function void note_error(string msg);
    if (error_count < 10) $display("%0t: %s", $time, msg);
    error_count++;
  endfunction

  function void check_result(book_result_t got);
    book_result_t want;
    string        bad;
    if (owed_results.size() == 0) begin
      note_error($sformatf("unexpected result status %0d", got.status));
      return;
    end
    want = owed_results.pop_front();
    bad  = "";
    if (got.status     !== want.status)     bad = {bad, " status"};
    if (got.evicted    !== want.evicted)    bad = {bad, " evicted_price"};
    if (got.best_valid !== want.best_valid) bad = {bad, " best_valid"};
    if (got.best_price !== want.best_price) bad = {bad, " best_price"};
    if (got.best_qty   !== want.best_qty)   bad = {bad, " best_quantity"};
    if (got.count      !== want.count)      bad = {bad, " side_level_count"};
    if (got.pad        !== want.pad)        bad = {bad, " pad"};
    if (bad != "")
      note_error($sformatf({"mismatch in%s: exp st=%0d ev=%h bv=%b bp=%h bq=%h n=%0d",
                            " / got st=%0d ev=%h bv=%b bp=%h bq=%h n=%0d p=%b"},
        bad, want.status, want.evicted, want.best_valid, want.best_price, want.best_qty,
        want.count, got.status, got.evicted, got.best_valid, got.best_price, got.best_qty,
        got.count, got.pad));
  endfunction
endclass

module tb_bounded_price_level_book;
  import bpl_pkg::*;

  // opcode the block does not define; it must come back as ignored
  localparam logic [1:0] FN_SPARE = 2'd3;
  // items (not counting ignored ones) before the random part stops
  localparam int unsigned ITEM_GOAL  = 1400;
  // from here on neither side idles
  localparam int unsigned CALM_AFTER = 1200;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // [31:0] price, [63:32] quantity
  logic [2:0]   s_axis_tuser = '0;   // [1:0] func, [2] side
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // [31:0] evicted_price, [63:32] best_price,
                                     // [95:64] best_quantity, [102:96] side_level_count,
                                     // [103] zero
  logic [3:0]   m_axis_tuser;        // [2:0] status, [3] best_valid

  book_mirror   book;
  bit           calm = 1'b0;
  int unsigned  items_done = 0;
  int unsigned  cycles = 0;
  int unsigned  ready_run = 0;
  int unsigned  ready_stall = 0;

  bounded_price_level_book dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Runaway guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver backpressure: ready stretches alternate with stalls; once calm is set, tready stays high.
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready = 1'b1;
    end else if (ready_run > 0) begin
      m_axis_tready = 1'b1;
      ready_run--;
    end else if (ready_stall > 0) begin
      m_axis_tready = 1'b0;
      ready_stall--;
    end else begin
      ready_run     = $urandom_range(0, 40);
      ready_stall   = $urandom_range(1, 18);
      m_axis_tready = 1'b1;
    end
  end

  // Result monitor: every master transaction is checked against the oldest outcome.
  always @(posedge clk_i) begin
    book_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.evicted    = m_axis_tdata[31:0];
      got.best_price = m_axis_tdata[63:32];
      got.best_qty   = m_axis_tdata[95:64];
      got.count      = m_axis_tdata[102:96];
      got.pad        = m_axis_tdata[103];
      got.status     = status_e'(m_axis_tuser[2:0]);
      got.best_valid = m_axis_tuser[3];
      book.check_result(got);
    end
  end

  // One slave transaction, with an optional idle burst ahead of it. tvalid stays
  // high across back-to-back transactions.
  task automatic send_update(input logic [1:0] fn, input logic sd,
                             input logic [31:0] px, input logic [31:0] qty);
    book_update_t     u;
    status_e          st;
    int unsigned      gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {qty, px};
    s_axis_tuser  = {sd, fn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    u.func  = fn;
    u.side  = sd;
    u.price = px;
    u.qty   = qty;
    st = book.take_update(u);
    if (st != RS_IGNORED) items_done++;
    if (items_done >= CALM_AFTER) calm = 1'b1;
  endtask

  // Hold off the sender until the block has returned every owed result.
  // tvalid drops first so the last transaction is not taken again.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (book.owed_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_qty(logic [1:0] fn);
    logic [31:0] q;
    case ($urandom_range(0, 7))
      0:       q = 32'hFFFF_FFFF;
      1:       q = 32'h1;
      default: q = $urandom;
    endcase
    // an update with zero would delete, so keep it nonzero there
    if (fn == FN_UPD && q == 0) q = 32'h1;
    if (fn == FN_ADD && $urandom_range(0, 9) == 0) q = 32'h0;
    return q;
  endfunction

  // New level (or a set when the price is already held).
  task automatic insert_level(input logic sd, input logic [31:0] px);
    logic [1:0] fn;
    fn = $urandom_range(0, 1) ? FN_UPD : FN_ADD;
    send_update(fn, sd, px, pick_qty(fn));
  endtask

  // Fill a side to capacity, then push on the tail: evictions, drops, hits.
  task automatic fill_side(input logic sd);
    int unsigned extra, idx, n;
    logic [31:0] tail, px;
    while (book.levels_held(sd) < DEPTH) insert_level(sd, $urandom);
    extra = $urandom_range(10, 40);
    repeat (extra) begin
      n    = book.levels_held(sd);
      tail = (n != 0) ? book.level_price(sd, n - 1) : 32'h0;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // ahead of the tail
          if (sd == 1'b0)
            px = (tail != 32'hFFFF_FFFF) ? $urandom_range(32'hFFFF_FFFF, tail + 1) : $urandom;
          else
            px = (tail != 32'h0) ? $urandom_range(tail - 1, 0) : $urandom;
          insert_level(sd, px);
        end
        3, 4: begin
          // behind the tail; the far extreme now and then
          if (sd == 1'b0)
            px = (tail == 0 || $urandom_range(0, 2) == 0) ? 32'h0 : $urandom_range(tail - 1, 0);
          else
            px = (tail == 32'hFFFF_FFFF || $urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF
                 : $urandom_range(32'hFFFF_FFFF, tail + 1);
          insert_level(sd, px);
        end
        5, 6, 8: begin
          if (n != 0) begin
            idx = $urandom_range(0, n - 1);
            px  = book.level_price(sd, idx);
            case ($urandom_range(0, 2))
              0: send_update(FN_UPD, sd, px, 32'h0);
              1: send_update(FN_UPD, sd, px, pick_qty(FN_UPD));
              default: send_update(FN_ADD, sd, px, pick_qty(FN_ADD));
            endcase
          end else begin
            insert_level(sd, $urandom);
          end
        end
        7: insert_level(sd, (sd == 1'b0) ? 32'hFFFF_FFFF : 32'h0);
        default: insert_level(sd, $urandom);
      endcase
    end
  endtask

  // Traffic around a handful of nearby prices: sets, deletes, re-inserts, the odd clear or spare opcode.
  task automatic churn_side(input logic sd);
    logic [31:0] base, px;
    int unsigned len, r;
    case ($urandom_range(0, 3))
      0:       base = 32'h0;
      1:       base = 32'hFFFF_FFF8;
      default: base = $urandom;
    endcase
    len = $urandom_range(15, 40);
    repeat (len) begin
      px = base + $urandom_range(0, 7);
      r  = $urandom_range(0, 99);
      if (r < 25)      send_update(FN_UPD, sd, px, 32'h0);
      else if (r < 60) send_update(FN_UPD, sd, px, pick_qty(FN_UPD));
      else if (r < 90) send_update(FN_ADD, sd, px, pick_qty(FN_ADD));
      else if (r < 93) send_update(FN_CLR, sd, $urandom, $urandom);
      else             send_update(FN_SPARE, sd, px, $urandom);
    end
  endtask

  // Broken or meaningless transactions with arbitrary fields.
  task automatic noise_burst();
    int unsigned len;
    len = $urandom_range(5, 15);
    repeat (len)
      send_update(2'($urandom_range(FN_UPD, FN_SPARE)), 1'($urandom_range(0, 1)), $urandom,
                  $urandom_range(0, 1) ? 32'h0 : $urandom);
  endtask

  initial begin
    int unsigned pick;
    book = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-side delete, spare opcode, extremes, set / remove / clear.
    send_update(FN_UPD,   1'b1, 32'h0000_1234, 32'h0);          // delete on empty side
    send_update(FN_SPARE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_update(FN_UPD,   1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_update(FN_UPD,   1'b0, 32'h0,         32'h1);
    send_update(FN_UPD,   1'b0, 32'h8000_0000, 32'h7);
    send_update(FN_ADD,   1'b0, 32'h0,         32'h0);          // zero qty stored
    send_update(FN_UPD,   1'b0, 32'hFFFF_FFFF, 32'h5);
    send_update(FN_UPD,   1'b0, 32'h8000_0000, 32'h0);
    send_update(FN_UPD,   1'b0, 32'hFFFF_FFFF, 32'h0);
    send_update(FN_UPD,   1'b0, 32'h5555_5555, 32'h0);          // delete of a missing price
    send_update(FN_ADD,   1'b1, 32'h0,         32'h0);          // new level, zero qty
    send_update(FN_ADD,   1'b1, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
    send_update(FN_UPD,   1'b1, 32'h5555_5555, 32'h5555_5555);
    send_update(FN_UPD,   1'b1, 32'h0,         32'h0);
    send_update(FN_SPARE, 1'b1, 32'h0,         32'h0);
    send_update(FN_CLR,   1'b0, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    send_update(FN_CLR,   1'b0, 32'h0,         32'h0);          // clear of an empty side
    send_update(FN_CLR,   1'b1, 32'hFFFF_FFFF, 32'h0);
    drain();

    // Both sides to capacity first, so evictions and drops show up early.
    fill_side(1'b0);
    fill_side(1'b1);
    drain();

    while (items_done < ITEM_GOAL) begin
      pick = $urandom_range(0, 19);
      if (pick < 8)       churn_side(1'($urandom_range(0, 1)));
      else if (pick < 14) fill_side(1'($urandom_range(0, 1)));
      else if (pick < 17) noise_burst();
      else begin
        send_update(FN_CLR, 1'($urandom_range(0, 1)), $urandom, $urandom);
        churn_side(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0) drain();
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    drain();
    repeat (16) @(posedge clk_i);
    if (book.owed_results.size() != 0)
      book.note_error($sformatf("%0d results never arrived", book.owed_results.size()));
    if (book.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
